// ----- sv/mtg_pkg.sv -----
// Shared constants and types for the multi-tap gesture detector.
// No dependencies; compile first.
package mtg_pkg;

  // Width of the wrapping time base used for all time arithmetic.
  localparam int TIME_BITS = 32;

  localparam int NOW_BITS    = 32;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 2;

  typedef logic [TIME_BITS-1:0]    time_t;
  typedef logic [CFG_BITS-1:0]     cfg_word_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  typedef logic [1:0]              opcode_t;
  typedef logic [1:0]              action_t;
  typedef logic [1:0]              taps_t;

  // Opcodes
  localparam opcode_t OP_BUTTON = 2'd0;
  localparam opcode_t OP_TICK   = 2'd1;
  localparam opcode_t OP_FLUSH  = 2'd2;
  localparam opcode_t OP_UNUSED = 2'd3;

  // Actions
  localparam action_t ACT_NONE     = 2'd0;
  localparam action_t ACT_PLAY     = 2'd1;
  localparam action_t ACT_NEXT     = 2'd2;
  localparam action_t ACT_PREVIOUS = 2'd3;

  // Configuration register indexes
  localparam cfg_idx_t REG_WINDOW_TICKS  = 2'd0;
  localparam cfg_idx_t REG_WAIT_FALLBACK = 2'd1;

  localparam cfg_word_t WINDOW_RESET   = 16'd50;
  localparam cfg_word_t FALLBACK_RESET = 16'd10;

  // Map a tap count onto its action.
  function automatic action_t taps_to_action(taps_t n);
    action_t a;
    unique case (n)
      2'd1:    a = ACT_PLAY;
      2'd2:    a = ACT_NEXT;
      2'd3:    a = ACT_PREVIOUS;
      default: a = ACT_NONE;
    endcase
    return a;
  endfunction

endpackage

// ----- sv/mtg_if.sv -----
// Handshake interfaces for the multi-tap gesture detector channels.
// Depends on mtg_pkg.
interface mtg_in_if;
  import mtg_pkg::*;
  logic      valid;
  logic      ready;
  opcode_t   opcode;
  logic [NOW_BITS-1:0] now_time;
  logic      target_hit;
  logic      released;
  logic      repeated;
  modport source (output valid, opcode, now_time, target_hit, released, repeated,
                  input ready);
  modport sink   (input valid, opcode, now_time, target_hit, released, repeated,
                  output ready);
endinterface

interface mtg_out_if;
  import mtg_pkg::*;
  logic      valid;
  logic      ready;
  action_t   action;
  cfg_word_t wait_hint;
  modport source (output valid, action, wait_hint, input ready);
  modport sink   (input valid, action, wait_hint, output ready);
endinterface

interface mtg_cfg_if;
  import mtg_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_word_t data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/multitap_gesture_detector_top.sv -----
// Top level of the multi-tap gesture detector.
// Depends on mtg_pkg and the channel interfaces in mtg_if.sv.

// Counts short presses of one watched button into a tap sequence and reports
// one result per input transaction: play/pause for one tap, next for two,
// previous for three, together with a suggested wait until the next tick.
// An item is captured in the input register, then a single pass of
// compare/add logic against the press state loads its result into the result
// register, from which the sink can take it. A new item is accepted every
// cycle unless both stages are full and the sink stalls; the only
// loop is the press state itself, which updates as an item moves into the
// result register, so back-to-back items see each other's effects in order.
// The output register decouples the two sides: the block keeps accepting
// while a result waits, and stalls only when both stages are full. The
// configuration port is always ready and is meant to be written while idle.
module multitap_gesture_detector_top (
  input logic clk,
  input logic rst,
  mtg_in_if.sink    items,
  mtg_out_if.source results,
  mtg_cfg_if.sink   cfg
);
  import mtg_pkg::*;

  // Configuration registers
  cfg_word_t tap_window;
  cfg_word_t wait_fallback;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_window    <= WINDOW_RESET;
      wait_fallback <= FALLBACK_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_WINDOW_TICKS)  tap_window    <= cfg.data;
      if (cfg.index == REG_WAIT_FALLBACK) wait_fallback <= cfg.data;
    end
  end

  // Zero in either register acts as one.
  time_t     win;
  cfg_word_t fb;
  assign win = (tap_window == '0) ? time_t'(1) : time_t'(tap_window);
  assign fb  = (wait_fallback == '0) ? cfg_word_t'(1) : wait_fallback;

  // Input register stage
  logic    s1_valid;
  opcode_t s1_opcode;
  time_t   s1_now;
  logic    s1_hit;
  logic    s1_rel;
  logic    s1_rep;

  // Result register stage
  logic      out_valid;
  action_t   out_action;
  cfg_word_t out_wait;

  logic s1_advance;
  logic in_take;

  // Advance the input stage whenever the result register is free or drains.
  assign s1_advance  = s1_valid && (!out_valid || results.ready);
  assign items.ready = !s1_valid || s1_advance;
  assign in_take     = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_opcode <= items.opcode;
      // Carry the time stamp onto the internal time base; both are the same width.
      s1_now    <= time_t'(items.now_time);
      s1_hit    <= items.target_hit;
      s1_rel    <= items.released;
      s1_rep    <= items.repeated;
    end
  end

  // Press and sequence state
  logic  btn_down,      btn_down_next;
  logic  btn_spoiled,   btn_spoiled_next;
  taps_t tap_total,     tap_total_next;
  time_t press_begin,   press_begin_next;
  time_t finish_deadline, finish_deadline_next;

  action_t   act_next;
  cfg_word_t wait_next;

  time_t since_deadline;
  time_t held;
  time_t remaining;
  logic  expired;
  logic  too_long;

  assign since_deadline = s1_now - finish_deadline;
  assign held           = s1_now - press_begin;
  // A pending sequence whose deadline has been reached ends here.
  assign expired  = !btn_down && (tap_total != '0) && !since_deadline[TIME_BITS-1];
  assign too_long = !held[TIME_BITS-1] && (held > win);

  always_comb begin
    btn_down_next        = btn_down;
    btn_spoiled_next     = btn_spoiled;
    tap_total_next       = tap_total;
    press_begin_next     = press_begin;
    finish_deadline_next = finish_deadline;
    act_next             = ACT_NONE;

    unique case (s1_opcode)
      OP_BUTTON: begin
        if (s1_hit) begin
          if (expired) begin
            act_next             = taps_to_action(tap_total);
            tap_total_next       = '0;
            finish_deadline_next = '0;
          end
          // Release wins over repeat when both are flagged.
          if (s1_rel) begin
            if (btn_down) begin
              btn_down_next = 1'b0;
              if (btn_spoiled || too_long) begin
                // Drop the sequence: bad press.
                btn_spoiled_next     = 1'b0;
                tap_total_next       = '0;
                finish_deadline_next = '0;
              end else if (tap_total == 2'd2) begin
                // Third tap finishes at once.
                act_next             = ACT_PREVIOUS;
                tap_total_next       = '0;
                finish_deadline_next = '0;
              end else begin
                tap_total_next       = tap_total + 2'd1;
                finish_deadline_next = s1_now + win;
              end
            end
          end else if (s1_rep) begin
            if (btn_down) begin
              btn_spoiled_next     = 1'b1;
              tap_total_next       = '0;
              finish_deadline_next = '0;
            end
          end else if (!btn_down) begin
            btn_down_next    = 1'b1;
            btn_spoiled_next = 1'b0;
            press_begin_next = s1_now;
          end
        end
      end
      OP_TICK: begin
        if (expired) begin
          act_next             = taps_to_action(tap_total);
          tap_total_next       = '0;
          finish_deadline_next = '0;
        end
      end
      OP_FLUSH: begin
        if (btn_down) begin
          btn_down_next        = 1'b0;
          btn_spoiled_next     = 1'b0;
          tap_total_next       = '0;
          press_begin_next     = '0;
          finish_deadline_next = '0;
        end else begin
          act_next             = taps_to_action(tap_total);
          tap_total_next       = '0;
          finish_deadline_next = '0;
        end
      end
      OP_UNUSED: begin
      end
      default: begin
      end
    endcase
  end

  // Wait hint from the updated state.
  assign remaining = finish_deadline_next - s1_now;

  always_comb begin
    if (btn_down_next || tap_total_next == '0) begin
      wait_next = fb;
    end else if (remaining == '0 || remaining[TIME_BITS-1]) begin
      wait_next = cfg_word_t'(1);
    end else if (remaining < time_t'(fb)) begin
      wait_next = remaining[CFG_BITS-1:0];
    end else begin
      wait_next = fb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      btn_down        <= 1'b0;
      btn_spoiled     <= 1'b0;
      tap_total       <= '0;
      press_begin     <= '0;
      finish_deadline <= '0;
    end else if (s1_advance) begin
      btn_down        <= btn_down_next;
      btn_spoiled     <= btn_spoiled_next;
      tap_total       <= tap_total_next;
      press_begin     <= press_begin_next;
      finish_deadline <= finish_deadline_next;
    end
  end

  // Result register: hold until the sink takes the transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_action <= act_next;
      out_wait   <= wait_next;
    end
  end

  assign results.valid     = out_valid;
  assign results.action    = out_action;
  assign results.wait_hint = out_wait;

endmodule

// ----- tb/sv/mtg_action_monitor.sv -----
// Passive monitor for the multi-tap gesture detector: predicts and checks each result.
// Depends on mtg_pkg and the channel interfaces in mtg_if.sv.
module mtg_action_monitor (
  input  logic clk,
  input  logic rst,
  mtg_in_if    items,
  mtg_out_if   results,
  mtg_cfg_if   cfg,
  output int   mismatch_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import mtg_pkg::*;

  typedef struct packed {
    action_t   action;
    cfg_word_t wait_hint;
  } tap_result_t;

  // Shadow copy of the press state and the two registers.
  logic        held_down;
  logic        held_spoiled;
  taps_t       tap_run;
  time_t       hold_start;
  time_t       tap_deadline;
  cfg_word_t   window_reg;
  cfg_word_t   fallback_reg;
  tap_result_t pending_actions[$];

  function automatic logic reached(time_t now, time_t mark);
    time_t d;
    d = now - mark;
    return !d[TIME_BITS-1];
  endfunction

  // End the tap run and return the action it stands for.
  function automatic action_t close_sequence();
    action_t a;
    case (tap_run)
      2'd1:    a = ACT_PLAY;
      2'd2:    a = ACT_NEXT;
      2'd3:    a = ACT_PREVIOUS;
      default: a = ACT_NONE;
    endcase
    tap_run      = '0;
    tap_deadline = '0;
    return a;
  endfunction

  function automatic void clear_press();
    held_down    = 1'b0;
    held_spoiled = 1'b0;
    tap_run      = '0;
    hold_start   = '0;
    tap_deadline = '0;
  endfunction

  function automatic tap_result_t predict_tap_action(opcode_t op, time_t now, logic hit,
                                                     logic rel, logic rep);
    tap_result_t r;
    time_t       win;
    time_t       held;
    time_t       left;
    cfg_word_t   fb;
    r.action = ACT_NONE;
    win = (window_reg == '0) ? time_t'(1) : time_t'(window_reg);
    fb  = (fallback_reg == '0) ? cfg_word_t'(1) : fallback_reg;
    case (op)
      OP_BUTTON: begin
        if (hit) begin
          if (!held_down && tap_run != '0 && reached(now, tap_deadline))
            r.action = close_sequence();
          if (rel) begin
            if (held_down) begin
              held_down = 1'b0;
              held = now - hold_start;
              if (held_spoiled || (!held[TIME_BITS-1] && held > win)) begin
                held_spoiled = 1'b0;
                tap_run      = '0;
                tap_deadline = '0;
              end else begin
                tap_run = tap_run + 2'd1;
                if (tap_run == 2'd3)
                  r.action = close_sequence();
                else
                  tap_deadline = now + win;
              end
            end
          end else if (rep) begin
            if (held_down) begin
              held_spoiled = 1'b1;
              tap_run      = '0;
              tap_deadline = '0;
            end
          end else if (!held_down) begin
            held_down    = 1'b1;
            held_spoiled = 1'b0;
            hold_start   = now;
          end
        end
      end
      OP_TICK: begin
        if (!held_down && tap_run != '0 && reached(now, tap_deadline))
          r.action = close_sequence();
      end
      OP_FLUSH: begin
        if (held_down)
          clear_press();
        else
          r.action = close_sequence();
      end
      default: ;
    endcase
    if (held_down || tap_run == '0) begin
      r.wait_hint = fb;
    end else begin
      left = tap_deadline - now;
      if (left == '0 || left[TIME_BITS-1])
        r.wait_hint = cfg_word_t'(1);
      else if (left < time_t'(fb))
        r.wait_hint = left[CFG_BITS-1:0];
      else
        r.wait_hint = fb;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    if (mismatch_count < 40)
      $display("%0t ns: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    tap_result_t want;
    if (rst) begin
      clear_press();
      window_reg     = WINDOW_RESET;
      fallback_reg   = FALLBACK_RESET;
      mismatch_count = 0;
      pending_actions.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_WINDOW_TICKS:  window_reg   = cfg.data;
          REG_WAIT_FALLBACK: fallback_reg = cfg.data;
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        if (pending_actions.size() == 0) begin
          flag_mismatch("unexpected result, wait_hint", int'(results.wait_hint), -1);
        end else begin
          want = pending_actions.pop_front();
          if (results.action !== want.action)
            flag_mismatch("action", int'(results.action), int'(want.action));
          if (results.wait_hint !== want.wait_hint)
            flag_mismatch("wait_hint", int'(results.wait_hint), int'(want.wait_hint));
        end
      end
      if (items.valid && items.ready)
        pending_actions.push_back(predict_tap_action(items.opcode, time_t'(items.now_time),
                                                     items.target_hit, items.released,
                                                     items.repeated));
    end
    outstanding = pending_actions.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
// Stimulus and verdict for the multi-tap gesture detector testbench.
// Depends on mtg_pkg, mtg_if.sv, the detector RTL and mtg_action_monitor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtg_pkg::*;

  localparam int STALL_MAX   = 18;
  // Longest legitimate quiet stretch is the deliberate hold-off plus a few
  // stalls; allow several times that.
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_ITEMS = 130;

  logic      clk = 1'b0;
  logic      rst;
  int        mismatches;
  int        in_flight;
  int        quiet_cycles;
  int        counted_items;
  time_t     t_now;
  cfg_word_t cur_window;
  // Idling modes: when set, that side runs with no gaps at all.
  bit        src_eager;
  bit        snk_eager;
  // Raised by the stimulus to ask the result side for one long hold-off.
  bit        choke_request;

  mtg_in_if  items_ch ();
  mtg_out_if results_ch ();
  mtg_cfg_if cfg_ch ();

  multitap_gesture_detector_top dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  mtg_action_monitor monitor (
    .clk            (clk),
    .rst            (rst),
    .items          (items_ch),
    .results        (results_ch),
    .cfg            (cfg_ch),
    .mismatch_count (mismatches),
    .outstanding    (in_flight)
  );

  always #5 clk = ~clk;

  // Watchdog: count cycles in which no channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (items_ch.valid && items_ch.ready) ||
        (results_ch.valid && results_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Result side: draw a stall per transaction, and honor a long hold-off
  // when the stimulus asks for one.
  initial begin
    int stall;
    results_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (choke_request) begin
        // Hold ready low long enough for both stages to fill and the
        // input side to back up.
        choke_request = 1'b0;
        results_ch.ready = 1'b0;
        repeat ($urandom_range(300, 400)) @(negedge clk);
      end
      stall = snk_eager ? 0 : $urandom_range(0, STALL_MAX);
      if (stall != 0) begin
        results_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      results_ch.ready = 1'b1;
      do @(posedge clk); while (!results_ch.valid);
      @(negedge clk);
    end
  end

  // Offer one item after a random gap and hold it until it is taken.
  // Returns at the rising edge that accepted it.
  task automatic send_item(opcode_t op, time_t stamp, logic hit, logic rel, logic rep);
    int gap;
    gap = src_eager ? 0 : $urandom_range(0, STALL_MAX);
    @(negedge clk);
    if (gap != 0) begin
      items_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    items_ch.valid      = 1'b1;
    items_ch.opcode     = op;
    items_ch.now_time   = stamp;
    items_ch.target_hit = hit;
    items_ch.released   = rel;
    items_ch.repeated   = rep;
    do @(posedge clk); while (!items_ch.ready);
    // Ignored items do not count toward the stimulus size.
    if ((op == OP_BUTTON && hit) || op == OP_TICK || op == OP_FLUSH)
      counted_items++;
  endtask

  task automatic push_down(time_t stamp);
    send_item(OP_BUTTON, stamp, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic lift(time_t stamp);
    send_item(OP_BUTTON, stamp, 1'b1, 1'b1, 1'b0);
  endtask

  // Ticks and flushes carry random flags; the block must ignore them.
  task automatic tick_at(time_t stamp);
    send_item(OP_TICK, stamp, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic flush_at(time_t stamp);
    send_item(OP_FLUSH, stamp, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic advance(time_t d);
    t_now = t_now + d;
  endtask

  function automatic time_t eff_window();
    return (cur_window == '0) ? time_t'(1) : time_t'(cur_window);
  endfunction

  // Spans measured against the tap window: well inside it, right on its
  // border (one below, equal, one above), and clearly past it.
  function automatic time_t short_span();
    return time_t'($urandom_range(0, eff_window() - 1));
  endfunction

  function automatic time_t border_span();
    return eff_window() - 1 + time_t'($urandom_range(0, 2));
  endfunction

  function automatic time_t long_span();
    return eff_window() + 1 + time_t'($urandom_range(0, 3 * eff_window()));
  endfunction

  function automatic time_t mixed_span(int pct_short);
    int r;
    r = $urandom_range(0, 99);
    if (r < pct_short)
      return short_span();
    else if (r < pct_short + (100 - pct_short) / 2)
      return border_span();
    return long_span();
  endfunction

  // Drop valid and wait until every expected result has been taken.
  task automatic settle();
    @(negedge clk);
    items_ch.valid = 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, cfg_word_t val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    if (idx == REG_WINDOW_TICKS)
      cur_window = val;
  endtask

  task automatic configure(cfg_word_t window, cfg_word_t fallback);
    settle();
    write_register(REG_WINDOW_TICKS, window);
    write_register(REG_WAIT_FALLBACK, fallback);
  endtask

  // One to three taps with random timing, some disturbed mid-press, then
  // a way of ending the run: ticks around the deadline, a flush, or the
  // next sequence's first press.
  task automatic tap_sequence();
    int    n;
    time_t lift_time;
    n = $urandom_range(1, 3);
    for (int k = 0; k < n; k++) begin
      if (k != 0)
        advance(mixed_span(80));
      push_down(t_now);
      if ($urandom_range(0, 7) == 0) begin
        advance(short_span() / 2);
        case ($urandom_range(0, 3))
          0: send_item(OP_BUTTON, t_now, 1'b1, 1'b0, 1'b1);   // auto-repeat spoils it
          1: push_down(t_now);                                 // second press ignored
          2: send_item(OP_BUTTON, t_now, 1'b0, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));              // other button
          default: tick_at(t_now);
        endcase
      end
      advance(mixed_span(85));
      send_item(OP_BUTTON, t_now, 1'b1, 1'b1, 1'($urandom_range(0, 9) == 0));
    end
    lift_time = t_now;
    case ($urandom_range(0, 4))
      0, 1, 2: begin
        tick_at(lift_time + short_span());
        tick_at(lift_time + border_span());
        t_now = lift_time + long_span();
        tick_at(t_now);
      end
      3: begin
        advance(short_span());
        flush_at(t_now);
      end
      default: advance(mixed_span(50));
    endcase
  endtask

  task automatic run_random_phase(int quota);
    int start;
    start = counted_items;
    t_now = time_t'($urandom);
    while (counted_items - start < quota) begin
      // Flip the idling modes now and then so both gappy and gapless
      // stretches occur on each side.
      if ($urandom_range(0, 15) == 0) src_eager = !src_eager;
      if ($urandom_range(0, 15) == 0) snk_eager = !snk_eager;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: tap_sequence();
        6: begin
          // Press held past the window cancels the run.
          push_down(t_now);
          advance(long_span());
          lift(t_now);
          advance(short_span());
          tick_at(t_now);
        end
        7: begin
          case ($urandom_range(0, 2))
            0: begin
              push_down(t_now);
              advance(short_span());
            end
            1: begin
              push_down(t_now);
              advance(short_span());
              lift(t_now);
              advance(short_span());
            end
            default: ;
          endcase
          flush_at(t_now);
        end
        8: begin
          // Noise: any opcode, any flags, watched or not.
          advance(short_span());
          send_item(opcode_t'($urandom_range(0, 3)), t_now, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        default: begin
          // Jump the clock, possibly across the wrap or by more than half
          // the range, sometimes with a tap pending.
          if ($urandom_range(0, 1) == 0) begin
            push_down(t_now);
            lift(t_now + short_span());
          end
          if ($urandom_range(0, 1) == 0)
            t_now = '1 - short_span();
          else
            advance(time_t'($urandom));
          tick_at(t_now);
        end
      endcase
    end
  endtask

  initial begin
    rst                 = 1'b1;
    items_ch.valid      = 1'b0;
    items_ch.opcode     = OP_BUTTON;
    items_ch.now_time   = '0;
    items_ch.target_hit = 1'b0;
    items_ch.released   = 1'b0;
    items_ch.repeated   = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_WINDOW_TICKS;
    cfg_ch.data         = '0;
    src_eager           = 1'b0;
    snk_eager           = 1'b0;
    choke_request       = 1'b0;
    cur_window          = WINDOW_RESET;
    counted_items       = 0;
    t_now               = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, reset settings (window 50, fallback 10).
    // Events that must change nothing.
    lift(32'd5);
    send_item(OP_BUTTON, 32'd6, 1'b1, 1'b0, 1'b1);
    send_item(OP_UNUSED, 32'd7, 1'b1, 1'b0, 1'b0);
    send_item(OP_BUTTON, 32'd8, 1'b0, 1'b0, 1'b0);
    // Single tap expiring at a tick.
    push_down(32'd100);
    lift(32'd110);
    tick_at(32'd160);
    // Double tap finished by the next press, then a triple tap that ends at once.
    push_down(32'd200);
    lift(32'd205);
    push_down(32'd210);
    lift(32'd215);
    push_down(32'd300);
    lift(32'd301);
    push_down(32'd302);
    lift(32'd303);
    push_down(32'd304);
    lift(32'd305);
    // Press held too long.
    push_down(32'd500);
    lift(32'd600);
    // Auto-repeat spoils the press; release with both flags set.
    push_down(32'd700);
    send_item(OP_BUTTON, 32'd710, 1'b1, 1'b0, 1'b1);
    send_item(OP_BUTTON, 32'd720, 1'b1, 1'b1, 1'b1);
    // Flush during a press, then flush with nothing pending.
    push_down(32'd800);
    flush_at(32'd805);
    flush_at(32'd806);
    // Tap across the wrap, a tick half the range away, then flush it out.
    push_down(32'hFFFF_FFF0);
    lift(32'h0000_0005);
    tick_at(32'h8000_0040);
    flush_at(32'hFFFF_FFFF);

    run_random_phase(PHASE_ITEMS - 10);

    // Zero registers act as one; ask for a long hold-off with a greedy sender.
    configure('0, '0);
    choke_request = 1'b1;
    src_eager     = 1'b1;
    run_random_phase(PHASE_ITEMS);

    configure('1, '1);
    run_random_phase(PHASE_ITEMS);

    configure(cfg_word_t'(1), cfg_word_t'(1));
    run_random_phase(PHASE_ITEMS);

    configure(cfg_word_t'($urandom_range(2, 200)), cfg_word_t'($urandom_range(1, 60)));
    choke_request = 1'b1;
    src_eager     = 1'b1;
    run_random_phase(PHASE_ITEMS);

    configure('1, cfg_word_t'(1));
    run_random_phase(PHASE_ITEMS);

    configure(cfg_word_t'(3), '1);
    run_random_phase(PHASE_ITEMS);

    // Drain and let the pipeline go quiet before the verdict.
    settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mtg_pkg.sv
sv/mtg_if.sv
sv/multitap_gesture_detector_top.sv
tb/sv/mtg_action_monitor.sv
tb/sv/tb.sv
